@@ sv/ctgc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar / GPS time converter package
// Transfer types, pipeline depth and the cumulative month-day table for the day-number
// formula.
// ----------------------------------------------------------------------------
package ctgc_pkg;

    localparam int NUM_STAGES = 9;
    localparam int CAL_STAGES = 5;

    localparam logic OP_CAL_TO_GPS = 1'b0;
    localparam logic OP_GPS_TO_CAL = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] sub_second;
        logic [12:0] gps_week;
        logic [19:0] tow_second;
    } t_in_item;

    typedef struct packed {
        logic [21:0] julian_day;
        logic [16:0] noon_seconds;
        logic [12:0] week_out;
        logic [19:0] week_seconds_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [19:0] fraction_out;
    } t_out_item;

    typedef struct packed {
        logic [21:0] julian_day;
        logic [16:0] noon_seconds;
        logic [12:0] week;
        logic [19:0] week_seconds;
        logic [11:0] year;
    } t_cal_res;

    typedef struct packed {
        logic [21:0] julian_day;
        logic [16:0] noon_seconds;
        logic [12:0] week;
        logic [19:0] week_seconds;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_gps_res;

    // floor(30.6001 * n) for n = 0 .. 17
    localparam int MONTH_TAB_LEN = 18;
    localparam logic [9:0] MONTH_TAB [MONTH_TAB_LEN] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153,
        10'd183, 10'd214, 10'd244, 10'd275, 10'd306, 10'd336,
        10'd367, 10'd397, 10'd428, 10'd459, 10'd489, 10'd520
    };

    localparam logic [12:0] WEEK_MAX = 13'd8191;

endpackage
`default_nettype wire

@@ sv/ctgc_cal_path.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar to GPS path
// Pivots the year, forms the Julian day and seconds since noon, then splits the
// elapsed time into GPS week and time of week.
// ----------------------------------------------------------------------------
module ctgc_cal_path (
    input  wire                                 i_clk,
    input  wire  [ctgc_pkg::NUM_STAGES-1:0]     i_adv,
    input  ctgc_pkg::t_in_item                  i_data,
    output ctgc_pkg::t_cal_res                  o_res
);

    localparam int DLY = ctgc_pkg::NUM_STAGES - ctgc_pkg::CAL_STAGES;

    // stage 1
    logic [11:0] n1_year, r1_year;
    logic [20:0] n1_ysum, r1_ysum;
    logic [9:0]  n1_mtab, r1_mtab;
    logic [17:0] n1_t,    r1_t;
    logic [4:0]  r1_day;
    logic        early;
    logic [11:0] y;
    logic [4:0]  midx;

    always_comb begin
        if (i_data.year < 12'd1900) begin
            n1_year = i_data.year + ((i_data.year < 12'd80) ? 12'd2000 : 12'd1900);
        end else begin
            n1_year = i_data.year;
        end
        early   = (i_data.month <= 4'd2);
        y       = n1_year - {11'd0, early};
        n1_ysum = 21'(y) * 21'd365 + 21'(y >> 2);
        midx    = early ? (5'(i_data.month) + 5'd13) : (5'(i_data.month) + 5'd1);
        n1_mtab = ctgc_pkg::MONTH_TAB[midx];
        n1_t    = 18'(i_data.hour) * 18'd3600 + 18'(i_data.minute) * 18'd60
                + 18'(i_data.second) + 18'd43200;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_year <= n1_year;
            r1_ysum <= n1_ysum;
            r1_mtab <= n1_mtab;
            r1_t    <= n1_t;
            r1_day  <= i_data.day;
        end
    end

    // stage 2
    logic        ge_day;
    logic [21:0] dsum;
    logic [16:0] n2_ns, r2_ns;
    logic [21:0] n2_jd, r2_jd;
    logic [19:0] n2_du, r2_du;
    logic [11:0] r2_year;

    always_comb begin
        ge_day = (r1_t >= 18'd86400);
        n2_ns  = 17'(r1_t - (ge_day ? 18'd86400 : 18'd0));
        dsum   = 22'(r1_ysum) + 22'(r1_mtab) + 22'(r1_day) + 22'(ge_day);
        n2_jd  = dsum + 22'd1720981;
        n2_du  = 20'(dsum - 22'd688263);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r2_ns   <= n2_ns;
            r2_jd   <= n2_jd;
            r2_du   <= n2_du;
            r2_year <= r1_year;
        end
    end

    // stage 3
    logic [35:0] prod7;
    logic [17:0] r3_q0;
    logic [19:0] r3_du;
    logic [16:0] r3_ns;
    logic [21:0] r3_jd;
    logic [11:0] r3_year;

    assign prod7 = 36'(r2_du) * 36'd37449;

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r3_q0   <= prod7[35:18];
            r3_du   <= r2_du;
            r3_ns   <= r2_ns;
            r3_jd   <= r2_jd;
            r3_year <= r2_year;
        end
    end

    // stage 4
    logic [19:0] rem7;
    logic        ge7;
    logic [17:0] q7;
    logic [2:0]  r0;
    logic [20:0] n4_x,  r4_x;
    logic [18:0] n4_wk, r4_wk;
    logic [16:0] r4_ns;
    logic [21:0] r4_jd;
    logic [11:0] r4_year;

    always_comb begin
        rem7  = r3_du - 20'(r3_q0) * 20'd7;
        ge7   = (rem7[3:0] >= 4'd7);
        q7    = r3_q0 + 18'(ge7);
        r0    = 3'(rem7[3:0] - (ge7 ? 4'd7 : 4'd0));
        n4_x  = 21'(r0) * 21'd86400 + 21'(r3_ns) - 21'd43200;
        n4_wk = 19'(q7) - 19'd5000;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r4_x    <= n4_x;
            r4_wk   <= n4_wk;
            r4_ns   <= r3_ns;
            r4_jd   <= r3_jd;
            r4_year <= r3_year;
        end
    end

    // stage 5
    logic        neg;
    logic [18:0] wk;
    ctgc_pkg::t_cal_res n5_res;
    ctgc_pkg::t_cal_res r_dly [DLY+1];

    always_comb begin
        neg = r4_x[20];
        wk  = r4_wk - 19'(neg);
        n5_res.julian_day   = r4_jd;
        n5_res.noon_seconds = r4_ns;
        n5_res.week_seconds = 20'(r4_x + (neg ? 21'd604800 : 21'd0));
        n5_res.year         = r4_year;
        if (wk[18]) begin
            n5_res.week = 13'd0;
        end else if (|wk[17:13]) begin
            n5_res.week = ctgc_pkg::WEEK_MAX;
        end else begin
            n5_res.week = wk[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ctgc_pkg::CAL_STAGES-1]) begin
            r_dly[0] <= n5_res;
        end
    end

    // hold the result level with the longer path
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_adv[ctgc_pkg::CAL_STAGES+k]) begin
                r_dly[k+1] <= r_dly[k];
            end
        end
    end

    assign o_res = r_dly[DLY];

endmodule
`default_nettype wire

@@ sv/ctgc_gps_path.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPS to calendar path
// Rebuilds the Julian day from week and time of week and splits it back into
// a civil date and time of day.
// ----------------------------------------------------------------------------
module ctgc_gps_path (
    input  wire                                 i_clk,
    input  wire  [ctgc_pkg::NUM_STAGES-1:0]     i_adv,
    input  ctgc_pkg::t_in_item                  i_data,
    output ctgc_pkg::t_gps_res                  o_res
);

    // stage 1
    logic        tge;
    logic [20:0] n1_t, r1_t;
    logic [15:0] n1_wn7, r1_wn7;
    ctgc_pkg::t_gps_res n1_res, r1_res;

    always_comb begin
        tge    = (i_data.tow_second >= 20'd604800);
        n1_t   = 21'(i_data.tow_second) + 21'd43200;
        n1_wn7 = 16'(i_data.gps_week) * 16'd7;
        n1_res = '0;
        n1_res.week_seconds = i_data.tow_second - (tge ? 20'd604800 : 20'd0);
        if (tge && (i_data.gps_week == ctgc_pkg::WEEK_MAX)) begin
            n1_res.week = ctgc_pkg::WEEK_MAX;
        end else begin
            n1_res.week = i_data.gps_week + 13'(tge);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_t   <= n1_t;
            r1_wn7 <= n1_wn7;
            r1_res <= n1_res;
        end
    end

    // stage 2
    logic [36:0] pday;
    logic [3:0]  r2_q0;
    logic [20:0] r2_t;
    logic [15:0] r2_wn7;
    ctgc_pkg::t_gps_res r2_res;

    assign pday = 37'(r1_t) * 37'd49710;

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r2_q0  <= pday[35:32];
            r2_t   <= r1_t;
            r2_wn7 <= r1_wn7;
            r2_res <= r1_res;
        end
    end

    // stage 3
    logic [17:0] rday;
    logic        gday;
    logic [3:0]  n3_q, r3_q;
    logic [15:0] r3_wn7;
    ctgc_pkg::t_gps_res n3_res, r3_res;

    always_comb begin
        rday   = 18'(r2_t - 21'(r2_q0) * 21'd86400);
        gday   = (rday >= 18'd86400);
        n3_q   = r2_q0 + 4'(gday);
        n3_res = r2_res;
        n3_res.noon_seconds = 17'(rday - (gday ? 18'd86400 : 18'd0));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r3_q   <= n3_q;
            r3_wn7 <= r2_wn7;
            r3_res <= n3_res;
        end
    end

    // stage 4
    logic        half;
    logic [16:0] inner;
    logic [37:0] phr;
    logic [21:0] r4_b;
    logic [25:0] r4_n;
    logic [4:0]  r4_h0;
    ctgc_pkg::t_gps_res n4_res, r4_res;

    always_comb begin
        half   = (r3_res.noon_seconds >= 17'd43200);
        inner  = 17'(r3_wn7) + 17'(r3_q) + 17'(half);
        phr    = 38'(r3_res.noon_seconds) * 38'd1193046;
        n4_res = r3_res;
        n4_res.julian_day = 22'd2444244 + 22'(r3_wn7) + 22'(r3_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r4_b   <= 22'd2445781 + 22'(inner);
            r4_n   <= 26'(inner) * 26'd20 + 26'd48913178;
            r4_h0  <= phr[36:32];
            r4_res <= n4_res;
        end
    end

    // stage 5
    logic [45:0] pc;
    logic [12:0] rhr;
    logic        ghr;
    logic [12:0] r5_c0;
    logic [25:0] r5_n;
    logic [21:0] r5_b;
    logic [11:0] r5_rm;
    ctgc_pkg::t_gps_res n5_res, r5_res;

    always_comb begin
        pc     = 46'(r4_n) * 46'd587948;
        rhr    = 13'(r4_res.noon_seconds - 17'(r4_h0) * 17'd3600);
        ghr    = (rhr >= 13'd3600);
        n5_res = r4_res;
        n5_res.hour = r4_h0 + 5'(ghr);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[4]) begin
            r5_c0  <= pc[44:32];
            r5_n   <= r4_n;
            r5_b   <= r4_b;
            r5_rm  <= 12'(rhr - (ghr ? 13'd3600 : 13'd0));
            r5_res <= n5_res;
        end
    end

    // stage 6
    logic [13:0] rc;
    logic [38:0] pmin;
    logic [12:0] r6_c;
    logic [5:0]  r6_m0;
    logic [11:0] r6_rm;
    logic [21:0] r6_b;
    ctgc_pkg::t_gps_res r6_res;

    always_comb begin
        rc   = 14'(r5_n - 26'(r5_c0) * 26'd7305);
        pmin = 39'(r5_rm) * 39'd71582788;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[5]) begin
            r6_c   <= r5_c0 + 13'(rc >= 14'd7305);
            r6_m0  <= pmin[37:32];
            r6_rm  <= r5_rm;
            r6_b   <= r5_b;
            r6_res <= r5_res;
        end
    end

    // stage 7
    logic [21:0] dd4;
    logic [6:0]  rsec;
    logic        gsec;
    logic [9:0]  r7_x;
    logic [12:0] r7_c;
    ctgc_pkg::t_gps_res n7_res, r7_res;

    always_comb begin
        dd4    = 22'(r6_c) * 22'd365 + 22'(r6_c >> 2);
        rsec   = 7'(r6_rm - 12'(r6_m0) * 12'd60);
        gsec   = (rsec >= 7'd60);
        n7_res = r6_res;
        n7_res.minute = r6_m0 + 6'(gsec);
        n7_res.second = 6'(rsec - (gsec ? 7'd60 : 7'd0));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[6]) begin
            r7_x   <= 10'(r6_b - dd4);
            r7_c   <= r6_c;
            r7_res <= n7_res;
        end
    end

    // stage 8
    logic [4:0]  n8_e, r8_e;
    logic [9:0]  r8_x;
    logic [12:0] r8_c;
    ctgc_pkg::t_gps_res r8_res;

    always_comb begin
        n8_e = 5'd0;
        for (int k = 1; k < ctgc_pkg::MONTH_TAB_LEN; k++) begin
            n8_e = n8_e + 5'(r7_x > ctgc_pkg::MONTH_TAB[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[7]) begin
            r8_e   <= n8_e;
            r8_x   <= r7_x;
            r8_c   <= r7_c;
            r8_res <= r7_res;
        end
    end

    // stage 9
    logic [4:0]  mo;
    logic        late;
    logic [5:0]  hr12;
    ctgc_pkg::t_gps_res n9_res, r9_res;

    always_comb begin
        mo     = (r8_e >= 5'd14) ? (r8_e - 5'd13) : (r8_e - 5'd1);
        late   = ((r8_e >= 5'd4) && (r8_e <= 5'd13)) || (r8_e >= 5'd16);
        hr12   = 6'(r8_res.hour) + 6'd12;
        n9_res = r8_res;
        n9_res.month = mo[3:0];
        n9_res.day   = 5'(r8_x - ctgc_pkg::MONTH_TAB[r8_e]);
        n9_res.year  = 12'(r8_c - 13'd4715 - 13'(late));
        n9_res.hour  = 5'((hr12 >= 6'd24) ? (hr12 - 6'd24) : hr12);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[8]) begin
            r9_res <= n9_res;
        end
    end

    assign o_res = r9_res;

endmodule
`default_nettype wire

@@ sv/calendar_gps_time_converter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar / GPS time converter
// Converts a civil date and time to Julian day and GPS week / time of week,
// or a GPS week / time of week back to a civil date and time.
//
// Input channel: i_valid, o_stall, i_data. A transfer happens on a rising
// edge with i_valid high and o_stall low. Output channel: o_valid, i_stall,
// o_data, with the same rule. The operation bit in each item picks the
// direction; the sub-second fraction is carried through untouched.
// An item runs through 9 register stages, the first loaded at the input
// transfer edge; o_valid rises once it reaches the last. With i_stall low,
// one item can be taken every cycle, so throughput is one item per cycle.
// The output is a select between the two paths after the last stage.
// When i_stall is high the full stages hold and bubbles close up; o_stall
// rises only once all 9 stages hold items. Nothing is lost or repeated.
// Reset empties the pipeline: o_valid and o_stall go low.
// ----------------------------------------------------------------------------
module calendar_gps_time_converter_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  ctgc_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  wire                   i_stall,
    output ctgc_pkg::t_out_item   o_data
);

    localparam int NS = ctgc_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;
    ctgc_pkg::t_in_item r_pay [NS];
    ctgc_pkg::t_cal_res cal_res;
    ctgc_pkg::t_gps_res gps_res;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pay[0] <= i_data;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    ctgc_cal_path u_cal (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_data (i_data),
        .o_res  (cal_res)
    );

    ctgc_gps_path u_gps (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_data (i_data),
        .o_res  (gps_res)
    );

    always_comb begin
        o_data.fraction_out = r_pay[NS-1].sub_second;
        if (r_pay[NS-1].operation == ctgc_pkg::OP_CAL_TO_GPS) begin
            o_data.julian_day       = cal_res.julian_day;
            o_data.noon_seconds     = cal_res.noon_seconds;
            o_data.week_out         = cal_res.week;
            o_data.week_seconds_out = cal_res.week_seconds;
            o_data.year_out         = cal_res.year;
            o_data.month_out        = r_pay[NS-1].month;
            o_data.day_out          = r_pay[NS-1].day;
            o_data.hour_out         = r_pay[NS-1].hour;
            o_data.minute_out       = r_pay[NS-1].minute;
            o_data.second_out       = r_pay[NS-1].second;
        end else begin
            o_data.julian_day       = gps_res.julian_day;
            o_data.noon_seconds     = gps_res.noon_seconds;
            o_data.week_out         = gps_res.week;
            o_data.week_seconds_out = gps_res.week_seconds;
            o_data.year_out         = gps_res.year;
            o_data.month_out        = gps_res.month;
            o_data.day_out          = gps_res.day;
            o_data.hour_out         = gps_res.hour;
            o_data.minute_out       = gps_res.minute;
            o_data.second_out       = gps_res.second;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled with a free stage");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.noon_seconds < 17'd86400)
                    && (o_data.week_seconds_out < 20'd604800))
        else $error("noon seconds or time of week out of range");

    a_gps_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_pay[NS-1].operation == ctgc_pkg::OP_GPS_TO_CAL)
        |-> (o_data.hour_out < 5'd24) && (o_data.minute_out < 6'd60)
            && (o_data.second_out < 6'd60))
        else $error("rebuilt time of day out of range");

endmodule
`default_nettype wire

@@ tb/calendar_gps_time_converter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Calendar / GPS time converter testbench
// Drives bursts of date/time and week/time-of-week conversions through the
// valid/stall channels, predicts each result in integer arithmetic and checks
// every output transfer in order against the predicted queue.
// ----------------------------------------------------------------------------
class conv_scoreboard;
    ctgc_pkg::t_out_item pending[$];
    int        n_errors;
    int        n_checked;
    int        n_cal;
    int        n_gps;

    function longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function longint clamp_week(longint w);
        if (w < 0) return 0;
        if (w > 8191) return 8191;
        return w;
    endfunction

    function ctgc_pkg::t_out_item convert(ctgc_pkg::t_in_item it);
        ctgc_pkg::t_out_item r;
        longint yr, y, m, t, jd, ns, el, wn, tow, a, b, c, d, e, mo;
        longint hr, mi, se, dy;
        yr  = longint'(it.year);
        wn  = longint'(it.gps_week);
        tow = longint'(it.tow_second);
        hr  = longint'(it.hour);
        mi  = longint'(it.minute);
        se  = longint'(it.second);
        dy  = longint'(it.day);
        if (it.operation == ctgc_pkg::OP_CAL_TO_GPS) begin
            if (yr < 1900) yr = yr + ((yr < 80) ? 2000 : 1900);
            y = yr;
            m = longint'(it.month);
            if (m <= 2) begin
                y = y - 1;
                m = m + 12;
            end
            t  = hr * 3600 + mi * 60 + se + 43200;
            jd = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + dy + 1720981
                 + t / 86400;
            ns = t % 86400;
            el = (jd - 2444244) * 86400 + ns - 43200;
            r.julian_day       = 22'(jd);
            r.noon_seconds     = 17'(ns);
            r.week_out         = 13'(clamp_week(fdiv(el, 604800)));
            r.week_seconds_out = 20'(el - fdiv(el, 604800) * 604800);
            r.year_out         = 12'(yr);
            r.month_out        = it.month;
            r.day_out          = it.day;
            r.hour_out         = it.hour;
            r.minute_out       = it.minute;
            r.second_out       = it.second;
        end else begin
            jd = 2444244 + 7 * wn + (tow + 43200) / 86400;
            ns = (tow + 43200) % 86400;
            a  = jd + ((ns >= 43200) ? 1 : 0);
            b  = a + 1537;
            c  = (20 * b - 2442) / 7305;
            d  = (1461 * c) / 4;
            e  = (10000 * (b - d)) / 306001;
            mo = e - 1 - 12 * (e / 14);
            r.julian_day       = 22'(jd);
            r.noon_seconds     = 17'(ns);
            r.week_out         = 13'(clamp_week(wn + tow / 604800));
            r.week_seconds_out = 20'(tow % 604800);
            r.year_out         = 12'(c - 4715 - (7 + mo) / 10);
            r.month_out        = 4'(mo);
            r.day_out          = 5'(b - d - (306001 * e) / 10000);
            r.hour_out         = 5'((ns / 3600 + 12) % 24);
            r.minute_out       = 6'((ns % 3600) / 60);
            r.second_out       = 6'(ns % 60);
        end
        r.fraction_out = it.sub_second;
        return r;
    endfunction

    function void note_input(ctgc_pkg::t_in_item it);
        pending.push_back(convert(it));
        if (it.operation == ctgc_pkg::OP_CAL_TO_GPS) n_cal++;
        else n_gps++;
    endfunction

    function void check_result(ctgc_pkg::t_out_item got);
        ctgc_pkg::t_out_item want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.julian_day !== want.julian_day)
            $display("%0t: julian_day exp %0d got %0d", $time, want.julian_day,
                     got.julian_day);
        if (got.noon_seconds !== want.noon_seconds)
            $display("%0t: noon_seconds exp %0d got %0d", $time, want.noon_seconds,
                     got.noon_seconds);
        if (got.week_out !== want.week_out)
            $display("%0t: week_out exp %0d got %0d", $time, want.week_out,
                     got.week_out);
        if (got.week_seconds_out !== want.week_seconds_out)
            $display("%0t: week_seconds_out exp %0d got %0d", $time,
                     want.week_seconds_out, got.week_seconds_out);
        if (got.year_out !== want.year_out)
            $display("%0t: year_out exp %0d got %0d", $time, want.year_out,
                     got.year_out);
        if (got.month_out !== want.month_out)
            $display("%0t: month_out exp %0d got %0d", $time, want.month_out,
                     got.month_out);
        if (got.day_out !== want.day_out)
            $display("%0t: day_out exp %0d got %0d", $time, want.day_out, got.day_out);
        if (got.hour_out !== want.hour_out)
            $display("%0t: hour_out exp %0d got %0d", $time, want.hour_out,
                     got.hour_out);
        if (got.minute_out !== want.minute_out)
            $display("%0t: minute_out exp %0d got %0d", $time, want.minute_out,
                     got.minute_out);
        if (got.second_out !== want.second_out)
            $display("%0t: second_out exp %0d got %0d", $time, want.second_out,
                     got.second_out);
        if (got.fraction_out !== want.fraction_out)
            $display("%0t: fraction_out exp %0d got %0d", $time, want.fraction_out,
                     got.fraction_out);
        if (got !== want) n_errors++;
    endfunction
endclass

module calendar_gps_time_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam logic CAL = ctgc_pkg::OP_CAL_TO_GPS;
    localparam logic GPS = ctgc_pkg::OP_GPS_TO_CAL;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                out_valid;
    logic                out_stall;
    ctgc_pkg::t_in_item  in_data;
    ctgc_pkg::t_out_item out_data;
    int                  idle_cycles;
    int                  stall_mode;

    conv_scoreboard sb;

    calendar_gps_time_converter_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (out_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (in_stall),
        .o_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic ctgc_pkg::t_in_item rand_item();
        ctgc_pkg::t_in_item it;
        logic [95:0]        raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(ctgc_pkg::t_in_item)-1:0];
        it.operation = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       it.year = 12'($urandom_range(0, 4095));
            1:       it.year = 12'($urandom_range(0, 99));
            2:       it.year = 12'($urandom_range(1900, 1980));
            default: it.year = 12'($urandom_range(1980, 2200));
        endcase
        if ($urandom_range(0, 9) != 0) begin
            it.month  = 4'($urandom_range(1, 12));
            it.day    = 5'($urandom_range(1, 31));
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
            it.second = 6'($urandom_range(0, 59));
        end
        if ($urandom_range(0, 9) != 0) it.tow_second = 20'($urandom_range(0, 604799));
        if ($urandom_range(0, 3) == 0) it.gps_week = 13'($urandom_range(0, 3000));
        return it;
    endfunction

    function automatic ctgc_pkg::t_in_item mk(logic op, int y, int mo, int d, int h,
                                              int mi, int s, int f, int w, int tw);
        ctgc_pkg::t_in_item it;
        it.operation  = op;
        it.year       = 12'(y);
        it.month      = 4'(mo);
        it.day        = 5'(d);
        it.hour       = 5'(h);
        it.minute     = 6'(mi);
        it.second     = 6'(s);
        it.sub_second = 20'(f);
        it.gps_week   = 13'(w);
        it.tow_second = 20'(tw);
        return it;
    endfunction

    task automatic send(ctgc_pkg::t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (out_stall) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic pause(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_bursts(int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            repeat (burst) send(rand_item());
            left = left - burst;
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
        end
        in_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !in_stall) sb.check_result(out_data);
            if ((out_valid && !in_stall) || (in_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: in_stall <= 1'b0;
                1: in_stall <= ($urandom_range(0, 3) == 0);
                2: in_stall <= ($urandom_range(0, 1) == 0);
                default: in_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_stall    = 1'b0;
        in_data     = '0;
        idle_cycles = 0;
        stall_mode  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(CAL, 1980, 1, 6, 0, 0, 0, 0, 0, 0));
        send(mk(CAL, 0, 1, 1, 0, 0, 0, 20'hFFFFF, 0, 0));
        send(mk(CAL, 79, 12, 31, 23, 59, 59, 1, 0, 0));
        send(mk(CAL, 80, 2, 29, 12, 0, 0, 0, 0, 0));
        send(mk(CAL, 1899, 3, 1, 0, 0, 0, 0, 0, 0));
        send(mk(CAL, 1900, 1, 5, 23, 59, 59, 0, 0, 0));
        send(mk(CAL, 4095, 15, 31, 31, 63, 63, 0, 8191, 20'hFFFFF));
        send(mk(CAL, 2024, 0, 0, 31, 63, 63, 0, 0, 0));
        send(mk(CAL, 2137, 10, 1, 0, 0, 0, 0, 0, 0));
        send(mk(CAL, 1980, 1, 5, 23, 59, 59, 0, 0, 0));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(GPS, 4095, 15, 31, 31, 63, 63, 20'hFFFFF, 8191, 604799));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 5, 8191, 20'hFFFFF));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 0, 1, 604800));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 0, 2300, 43199));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 0, 2300, 43200));
        send(mk(GPS, 0, 0, 0, 0, 0, 0, 0, 1000, 86399));
        in_valid <= 1'b0;

        send_bursts(650);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (ctgc_pkg::NUM_STAGES * 3) @(posedge clk);
        $display("Checked %0d results: %0d calendar-to-GPS and %0d GPS-to-calendar inputs",
                 sb.n_checked, sb.n_cal, sb.n_gps);
        $display("Bursty input with random output stall patterns; %0d mismatching results",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/ctgc_pkg.sv
sv/ctgc_cal_path.sv
sv/ctgc_gps_path.sv
sv/calendar_gps_time_converter_unit.sv
tb/calendar_gps_time_converter_unit_tb.sv
